### sv/mwpo_pkg.sv
// ----------------------------------------------------------------------------
// mwpo_pkg
// Shared constants, codes and the quarter-wave sine table of the oscillator.
// ----------------------------------------------------------------------------
package mwpo_pkg;

    // sample format, Q1.(SAMPLE_BITS-1)
    localparam int SAMPLE_BITS = 16;
    localparam int MAG_BITS    = SAMPLE_BITS + 1;
    localparam int WIDE_BITS   = SAMPLE_BITS + 2;

    // phase defaults and configuration word
    localparam int PHASE_BITS_DEF = 32;
    localparam int TUNING_BITS    = 32;
    localparam int CFG_IDX_BITS   = 2;

    // quarter-wave table
    localparam int SINE_DEPTH     = 256;
    localparam int SINE_K_BITS    = $clog2(SINE_DEPTH);
    localparam int SINE_ADDR_BITS = SINE_K_BITS + 1;
    localparam int SINE_IDX_BITS  = SINE_K_BITS + 2;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_TUNING = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WAVE   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE = 2'd2;

    // waveform codes
    localparam logic [1:0] WAVE_SINE   = 2'd0;
    localparam logic [1:0] WAVE_SAW    = 2'd1;
    localparam logic [1:0] WAVE_RAMP   = 2'd2;
    localparam logic [1:0] WAVE_SQUARE = 2'd3;

    // reset values
    localparam logic [TUNING_BITS-1:0] TUNING_RESET = 32'd39370535;

    typedef logic [SINE_DEPTH:0][MAG_BITS-1:0] t_sine_rom;

    // one table entry: taylor series in Q30, rounded half up
    function automatic logic [MAG_BITS-1:0] sine_entry(input int k);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] rnd;
        x    = (64'(k) * HALF_PI_Q30) / SINE_DEPTH;
        term = x;
        sum  = x;
        for (int n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (n)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                6:       term = term / 156;
                default: term = term / 210;
            endcase
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        rnd = ((sum << (SAMPLE_BITS - 1)) + (64'd1 << 29)) >> 30;
        return rnd[MAG_BITS-1:0];
    endfunction

    // full quarter wave, entries 0 to SINE_DEPTH
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    // clamp a wide signed value into the sample range
    function automatic logic [SAMPLE_BITS-1:0] saturate(input logic signed [WIDE_BITS-1:0] v);
        logic signed [WIDE_BITS-1:0] hi;
        logic signed [WIDE_BITS-1:0] lo;
        hi = WIDE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
        lo = -WIDE_BITS'(1 << (SAMPLE_BITS - 1));
        if (v > hi) begin
            return hi[SAMPLE_BITS-1:0];
        end else if (v < lo) begin
            return lo[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

### sv/mwpo_phase_acc.sv
// ----------------------------------------------------------------------------
// mwpo_phase_acc
// Phase accumulator: holds the phase and advances it by the tuning word.
// ----------------------------------------------------------------------------
module mwpo_phase_acc
    import mwpo_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic [PHASE_BITS-1:0] i_tuning,
    output logic [PHASE_BITS-1:0] o_phase,
    output logic [PHASE_BITS-1:0] o_phase_next
);

    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;

    // wrap modulo 2^PHASE_BITS, one full turn of phase
    assign n_phase = r_phase + i_tuning;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
        end
    end

    assign o_phase      = r_phase;
    assign o_phase_next = n_phase;

endmodule

### sv/mwpo_wave_gen.sv
// ----------------------------------------------------------------------------
// mwpo_wave_gen
// Waveform shaper: sine from the quarter-wave table, saw, ramp and square.
// ----------------------------------------------------------------------------
module mwpo_wave_gen
    import mwpo_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic [1:0]             i_wave,
    input  logic [PHASE_BITS-1:0]  i_phase,
    input  logic [PHASE_BITS-1:0]  i_phase_next,
    output logic [SAMPLE_BITS-1:0] o_sample
);

    logic [SINE_IDX_BITS-1:0]     w_idx;
    logic [1:0]                   w_quad;
    logic [SINE_K_BITS-1:0]       w_k;
    logic [SINE_ADDR_BITS-1:0]    w_addr;
    logic [MAG_BITS-1:0]          w_mag;
    logic signed [WIDE_BITS-1:0]  w_sine_wide;
    logic [SAMPLE_BITS-1:0]       w_u;
    logic signed [WIDE_BITS-1:0]  w_ramp_wide;
    logic [SAMPLE_BITS-1:0]       w_full;

    // sine uses the phase before the advance
    assign w_idx  = i_phase[PHASE_BITS-1 -: SINE_IDX_BITS];
    assign w_quad = w_idx[SINE_IDX_BITS-1 -: 2];
    assign w_k    = w_idx[SINE_K_BITS-1:0];

    // odd quadrants read the table backwards
    assign w_addr = w_quad[0] ? (SINE_ADDR_BITS'(SINE_DEPTH) - {1'b0, w_k})
                              : {1'b0, w_k};
    assign w_mag  = SINE_ROM[w_addr];

    // lower half cycle negates
    assign w_sine_wide = w_quad[1] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});

    // other shapes use the top sample bits of the advanced phase
    assign w_u    = i_phase_next[PHASE_BITS-1 -: SAMPLE_BITS];
    assign w_full = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    assign w_ramp_wide = $signed({2'b00, w_full}) - $signed({2'b00, w_u});

    always_comb begin
        case (i_wave)
            WAVE_SINE:   o_sample = saturate(w_sine_wide);
            WAVE_SAW:    o_sample = {~w_u[SAMPLE_BITS-1], w_u[SAMPLE_BITS-2:0]};
            WAVE_RAMP:   o_sample = saturate(w_ramp_wide);
            WAVE_SQUARE: o_sample = w_u[SAMPLE_BITS-1] ? ~w_full : w_full;
            default:     o_sample = '0;
        endcase
    end

endmodule

### sv/multi_waveform_phase_oscillator_unit.sv
// ----------------------------------------------------------------------------
// multi_waveform_phase_oscillator_unit
// Numerically controlled oscillator with sine, rising saw, falling ramp and
// square outputs. Every accepted tick item with a set tick bit, while the
// oscillator is enabled, yields one signed Q1.15 sample and advances the
// phase by the tuning word (frequency / sample rate * 2^32); other ticks are
// taken and produce nothing. One tick is accepted per clock cycle while the
// output register is empty or being drained. The phase add, the quarter-wave
// table read and the waveform select sit between the phase register and the
// output register, so a sample appears in the cycle after its tick is taken.
// The output register decouples the sides. Configuration (tuning word,
// waveform, enable) is written through a plain write port; the user must
// write it only while no item is in flight: the block does not enforce it.
// ----------------------------------------------------------------------------
module multi_waveform_phase_oscillator_unit
    import mwpo_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [TUNING_BITS-1:0]  i_cfg_wdata,
    // tick channel
    input  logic                    i_tick_valid,
    output logic                    o_tick_ready,
    input  logic                    i_tick,
    // sample channel
    output logic                    o_sample_valid,
    input  logic                    i_sample_ready,
    output logic [SAMPLE_BITS-1:0]  o_sample
);

    logic [TUNING_BITS-1:0] r_tuning;
    logic [1:0]             r_wave;
    logic                   r_enable;
    logic                   r_valid;
    logic                   n_valid;
    logic [SAMPLE_BITS-1:0] r_sample;

    logic                   w_accept;
    logic                   w_fire;
    logic [PHASE_BITS-1:0]  w_tuning;
    logic [PHASE_BITS-1:0]  w_phase;
    logic [PHASE_BITS-1:0]  w_phase_next;
    logic [SAMPLE_BITS-1:0] w_sample;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tuning <= TUNING_RESET;
            r_wave   <= WAVE_SINE;
            r_enable <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_TUNING: r_tuning <= i_cfg_wdata;
                REG_WAVE:   r_wave   <= i_cfg_wdata[1:0];
                REG_ENABLE: r_enable <= i_cfg_wdata[0];
                default:    r_enable <= r_enable;
            endcase
        end
    end

    // handshake
    assign o_tick_ready = !r_valid || i_sample_ready;
    assign w_accept     = i_tick_valid && o_tick_ready;
    assign w_fire       = w_accept && i_tick && r_enable;

    // tuning word masked or extended to the phase width
    assign w_tuning = PHASE_BITS'(r_tuning);

    mwpo_phase_acc #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_fire),
        .i_tuning     (w_tuning),
        .o_phase      (w_phase),
        .o_phase_next (w_phase_next)
    );

    mwpo_wave_gen #(
        .PHASE_BITS (PHASE_BITS)
    ) u_wave_gen (
        .i_wave       (r_wave),
        .i_phase      (w_phase),
        .i_phase_next (w_phase_next),
        .o_sample     (w_sample)
    );

    // output register
    always_comb begin
        if (w_fire) begin
            n_valid = 1'b1;
        end else if (i_sample_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_sample <= w_sample;
        end
    end

    assign o_sample_valid = r_valid;
    assign o_sample       = r_sample;

endmodule

### bench/tb_multi_waveform_phase_oscillator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_waveform_phase_oscillator_unit
// Self-checking bench for the oscillator. A queue-fed driver offers tick
// items and a clocked monitor drains samples, both with random idle bursts.
// Every accepted tick runs through a local phase accumulator and waveform
// predictor, and each sample taken is compared with the oldest prediction.
// A directed opening covers the quadrant edges, saturation, masked and
// ignored register writes, then random settings carry the bulk of the run.
// ----------------------------------------------------------------------------
module tb_multi_waveform_phase_oscillator_unit;
    import mwpo_pkg::*;

    localparam int PHASE_W          = PHASE_BITS_DEF;
    localparam int FULL_SCALE       = 1 << (SAMPLE_BITS - 1);
    localparam int TICK_TARGET      = 1130;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_AT     = 300;
    localparam int LONG_HOLD_QUEUE  = 16;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int CYCLE_LIMIT      = 200000;

    // index that maps to no register
    localparam logic [CFG_IDX_BITS-1:0] REG_NONE = 2'd3;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_cfg_wr_en    = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx      = '0;
    logic [TUNING_BITS-1:0]  i_cfg_wdata    = '0;
    logic                    i_tick_valid   = 1'b0;
    logic                    o_tick_ready;
    logic                    i_tick         = 1'b0;
    logic                    o_sample_valid;
    logic                    i_sample_ready = 1'b0;
    logic [SAMPLE_BITS-1:0]  o_sample;

    // predictor state and configuration copy
    logic [PHASE_W-1:0]      osc_phase;
    logic [TUNING_BITS-1:0]  osc_tuning;
    logic [1:0]              osc_wave;
    logic                    osc_enable;
    int                      sine_quarter [0:SINE_DEPTH];

    // traffic bookkeeping
    logic                    tick_queue [$];
    logic [SAMPLE_BITS-1:0]  sample_expected [$];
    bit                      no_idle = 1'b0;
    int                      send_gap = 0;
    int                      recv_hold = 0;
    bit                      long_hold_done = 1'b0;
    int                      ticks_taken = 0;
    int                      samples_checked = 0;
    int                      settings_written = 0;
    int                      fail_count = 0;
    int                      cycle_count = 0;

    multi_waveform_phase_oscillator_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_tick_valid   (i_tick_valid),
        .o_tick_ready   (o_tick_ready),
        .i_tick         (i_tick),
        .o_sample_valid (o_sample_valid),
        .i_sample_ready (i_sample_ready),
        .o_sample       (o_sample)
    );

    always #5 i_clk = ~i_clk;

    // quarter-wave magnitude: taylor series of sin in Q30, rounded half up
    function automatic int quarter_sine(input int k);
        longint unsigned angle;
        longint unsigned term;
        longint unsigned acc;
        angle = (longint'(k) * HALF_PI_Q30) / SINE_DEPTH;
        term  = angle;
        acc   = angle;
        for (int n = 1; n <= 7; n++) begin
            term = (term * angle) >> 30;
            term = (term * angle) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            acc  = (n % 2 == 1) ? acc - term : acc + term;
        end
        return int'(((acc << (SAMPLE_BITS - 1)) + (64'd1 << 29)) >> 30);
    endfunction

    function automatic int clamp_sample(input int v);
        if (v > FULL_SCALE - 1) begin
            return FULL_SCALE - 1;
        end else if (v < -FULL_SCALE) begin
            return -FULL_SCALE;
        end
        return v;
    endfunction

    // expected sample for one accepted tick, phase advanced as the block does
    task automatic predict_tick(input logic tick_bit);
        logic [SINE_IDX_BITS-1:0] idx;
        logic [SINE_K_BITS-1:0]   pos;
        logic [SAMPLE_BITS-1:0]   top;
        int                       value;
        if (!tick_bit || !osc_enable) begin
            return;
        end
        if (osc_wave == WAVE_SINE) begin
            // sine reads the phase before the advance
            idx = osc_phase[PHASE_W-1 -: SINE_IDX_BITS];
            pos = idx[SINE_K_BITS-1:0];
            value = idx[SINE_K_BITS] ? sine_quarter[SINE_DEPTH - pos] : sine_quarter[pos];
            if (idx[SINE_K_BITS+1]) begin
                value = -value;
            end
            value = clamp_sample(value);
            osc_phase = osc_phase + osc_tuning;
        end else begin
            osc_phase = osc_phase + osc_tuning;
            top = osc_phase[PHASE_W-1 -: SAMPLE_BITS];
            case (osc_wave)
                WAVE_SAW:  value = int'(top) - FULL_SCALE;
                WAVE_RAMP: value = clamp_sample(FULL_SCALE - int'(top));
                default:   value = (int'(top) < FULL_SCALE) ? -FULL_SCALE : FULL_SCALE - 1;
            endcase
        end
        sample_expected.push_back(SAMPLE_BITS'(value));
    endtask

    // register write, mirrored into the predictor's copy
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [TUNING_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_TUNING: osc_tuning = data;
            REG_WAVE:   osc_wave   = data[1:0];
            REG_ENABLE: osc_enable = data[0];
            default:    ;
        endcase
        settings_written++;
    endtask

    // wait until every tick is taken and every sample is out
    task automatic drain();
        while (tick_queue.size() != 0 || i_tick_valid || sample_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // tick driver
    always @(posedge i_clk) begin
        if (i_rst_n && i_tick_valid && o_tick_ready) begin
            predict_tick(i_tick);
            ticks_taken++;
        end
        if (!i_tick_valid || o_tick_ready) begin
            if (send_gap != 0) begin
                send_gap     <= send_gap - 1;
                i_tick_valid <= 1'b0;
            end else if (tick_queue.size() != 0 && !no_idle && $urandom_range(0, 7) == 0) begin
                send_gap     <= $urandom_range(0, 8);
                i_tick_valid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
                i_tick_valid <= 1'b1;
                i_tick       <= tick_queue.pop_front();
            end else begin
                i_tick_valid <= 1'b0;
            end
        end
    end

    // sample monitor and receiver stalls
    always @(posedge i_clk) begin : sample_monitor
        logic [SAMPLE_BITS-1:0] want;
        if (i_rst_n && o_sample_valid && i_sample_ready) begin
            if (sample_expected.size() == 0) begin
                $error("sample: expected none, actual %0d", $signed(o_sample));
                fail_count++;
            end else begin
                want = sample_expected.pop_front();
                if (o_sample !== want) begin
                    $error("sample: expected %0d, actual %0d", $signed(want), $signed(o_sample));
                    fail_count++;
                end
            end
            samples_checked++;
        end
        if (recv_hold != 0) begin
            recv_hold      <= recv_hold - 1;
            i_sample_ready <= 1'b0;
        end else if (!long_hold_done && samples_checked >= LONG_HOLD_AT
                     && tick_queue.size() > LONG_HOLD_QUEUE) begin
            // one long hold so the output fills and ticks back up
            long_hold_done <= 1'b1;
            recv_hold      <= LONG_HOLD_CYCLES - 1;
            i_sample_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            recv_hold      <= $urandom_range(0, 8);
            i_sample_ready <= 1'b0;
        end else begin
            i_sample_ready <= 1'b1;
        end
    end

    // run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        int                     planned;
        int                     burst;
        logic                   tick_bit;
        logic [TUNING_BITS-1:0] tuning;
        planned = 0;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            sine_quarter[k] = quarter_sine(k);
        end
        osc_phase  = '0;
        osc_tuning = TUNING_RESET;
        osc_wave   = WAVE_SINE;
        osc_enable = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // disabled after reset: ticks are taken, nothing comes out
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b1);
        drain();

        // enable via wide write, sine in quarter steps, with an empty tick
        write_reg(REG_ENABLE, 32'hFFFF_FFF1);
        write_reg(REG_TUNING, 32'h4000_0000);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b1);
        drain();

        // write to the unused index must not touch the tuning word
        write_reg(REG_NONE, 32'h0000_0000);
        write_reg(REG_WAVE, 32'hFFFF_FFF5);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b1);
        drain();

        // square at half-cycle steps hits both levels
        write_reg(REG_WAVE, TUNING_BITS'(WAVE_SQUARE));
        write_reg(REG_TUNING, 32'h8000_0000);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b1);
        drain();

        // falling ramp at zero phase saturates, then a frozen phase
        write_reg(REG_WAVE, 32'hFFFF_FFF6);
        tick_queue.push_back(1'b1);
        drain();
        write_reg(REG_TUNING, 32'h0000_0000);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b1);
        drain();

        // saw with the largest tuning word walks backwards
        write_reg(REG_WAVE, TUNING_BITS'(WAVE_SAW));
        write_reg(REG_TUNING, 32'hFFFF_FFFF);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b1);
        drain();

        // disable via wide write
        write_reg(REG_ENABLE, 32'hFFFF_FFFE);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b1);
        drain();

        // random settings, each followed by a burst of ticks
        while (planned < TICK_TARGET) begin
            if (planned >= TICK_TARGET - 120) begin
                no_idle = 1'b1;
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0:       tuning = 32'h0000_0000;
                    1:       tuning = 32'hFFFF_FFFF;
                    2:       tuning = 32'h8000_0000;
                    3:       tuning = $urandom_range(1, 1 << 16);
                    default: tuning = $urandom();
                endcase
                write_reg(REG_TUNING, tuning);
            end
            if ($urandom_range(0, 3) != 0) begin
                write_reg(REG_WAVE, $urandom());
            end
            if ($urandom_range(0, 5) == 0) begin
                write_reg(REG_NONE, $urandom());
            end
            write_reg(REG_ENABLE, ($urandom() & ~32'h1) | ($urandom_range(0, 6) != 0));
            burst = $urandom_range(40, 160);
            if (burst > TICK_TARGET - planned) begin
                burst = TICK_TARGET - planned;
            end
            for (int n = 0; n < burst; n++) begin
                tick_bit = ($urandom_range(0, 19) != 0);
                tick_queue.push_back(tick_bit);
                planned++;
            end
            drain();
        end

        $display("ticks taken: %0d, samples checked: %0d, register writes: %0d",
                 ticks_taken, samples_checked, settings_written);
        $display("covered all four waveforms, quadrant edges, saturation and random tuning");
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
